>>> rtl/nec_ir_pkg.sv
// Types, constants and helper functions shared by the NEC infrared frame decoder.
`timescale 1ns / 1ps

package nec_ir_pkg;

  localparam int unsigned TicksW = 15;
  localparam int unsigned UsW    = 16;
  localparam int unsigned WordW  = 32;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [UsW-1:0] HdrMarkRst  = 16'd9000;
  localparam logic [UsW-1:0] HdrSpaceRst = 16'd4500;
  localparam logic [UsW-1:0] BitMarkRst  = 16'd560;
  localparam logic [UsW-1:0] OneSpaceRst = 16'd1690;
  localparam logic [UsW-1:0] ZeroSpaceRst = 16'd560;
  localparam logic [UsW-1:0] TolRst      = 16'd200;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LEVEL = 3'd0,
    CFG_HDR_MARK     = 3'd1,
    CFG_HDR_SPACE    = 3'd2,
    CFG_BIT_MARK     = 3'd3,
    CFG_ONE_SPACE    = 3'd4,
    CFG_ZERO_SPACE   = 3'd5,
    CFG_TOLERANCE    = 3'd6,
    CFG_UNUSED       = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_BITS = 2'd1,
    PH_END  = 2'd2,
    PH_DROP = 2'd3
  } phase_e;

  typedef struct packed {
    logic           active_level;
    logic [UsW-1:0] header_mark_us;
    logic [UsW-1:0] header_space_us;
    logic [UsW-1:0] bit_mark_us;
    logic [UsW-1:0] one_space_us;
    logic [UsW-1:0] zero_space_us;
    logic [UsW-1:0] tolerance_us;
  } cfg_t;

  typedef struct packed {
    logic first_level;
    logic [TicksW-1:0] first_ticks;
    logic second_level;
    logic [TicksW-1:0] second_ticks;
    logic buffer_end;
  } pair_t;

  typedef struct packed {
    logic header;
    logic one;
    logic zero;
  } match_t;

  // us = (ticks * 10) >> 3, built from two shifts
  function automatic logic [UsW-1:0] ticks_to_us(input logic [TicksW-1:0] ticks);
    logic [TicksW+3:0] prod;
    prod = {1'b0, ticks, 3'b000} + {3'b000, ticks, 1'b0};
    return prod[TicksW+3:3];
  endfunction

  // strict window: target - tol < us < target + tol
  function automatic logic near_target(input logic [UsW-1:0] us,
                                       input logic [UsW-1:0] target,
                                       input logic [UsW-1:0] tol);
    logic [UsW:0] hi;
    logic [UsW:0] us_tol;
    hi     = {1'b0, target} + {1'b0, tol};
    us_tol = {1'b0, us} + {1'b0, tol};
    return ({1'b0, us} < hi) && (us_tol > {1'b0, target});
  endfunction

endpackage

>>> rtl/nec_ir_cfg.sv
// Configuration register file of the NEC infrared frame decoder.
`timescale 1ns / 1ps

module nec_ir_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nec_ir_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [nec_ir_pkg::UsW-1:0]     cfg_wdata_i,
  output nec_ir_pkg::cfg_t               cfg_o
);
  import nec_ir_pkg::*;

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACTIVE_LEVEL: cfg_d.active_level    = cfg_wdata_i[0];
        CFG_HDR_MARK:     cfg_d.header_mark_us  = cfg_wdata_i;
        CFG_HDR_SPACE:    cfg_d.header_space_us = cfg_wdata_i;
        CFG_BIT_MARK:     cfg_d.bit_mark_us     = cfg_wdata_i;
        CFG_ONE_SPACE:    cfg_d.one_space_us    = cfg_wdata_i;
        CFG_ZERO_SPACE:   cfg_d.zero_space_us   = cfg_wdata_i;
        CFG_TOLERANCE:    cfg_d.tolerance_us    = cfg_wdata_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_level    <= 1'b0;
      cfg_q.header_mark_us  <= HdrMarkRst;
      cfg_q.header_space_us <= HdrSpaceRst;
      cfg_q.bit_mark_us     <= BitMarkRst;
      cfg_q.one_space_us    <= OneSpaceRst;
      cfg_q.zero_space_us   <= ZeroSpaceRst;
      cfg_q.tolerance_us    <= TolRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/nec_ir_match.sv
// Pulse pair classifier: header, one bit and zero bit window checks.
`timescale 1ns / 1ps

module nec_ir_match (
  input  nec_ir_pkg::pair_t  pair_i,
  input  nec_ir_pkg::cfg_t   cfg_i,
  output nec_ir_pkg::match_t match_o
);
  import nec_ir_pkg::*;

  logic [UsW-1:0] mark_us;
  logic [UsW-1:0] space_us;
  logic           levels_ok;

  assign mark_us   = ticks_to_us(pair_i.first_ticks);
  assign space_us  = ticks_to_us(pair_i.second_ticks);
  assign levels_ok = (pair_i.first_level == cfg_i.active_level) &&
                     (pair_i.second_level != cfg_i.active_level);

  assign match_o.header = levels_ok &&
      near_target(mark_us, cfg_i.header_mark_us, cfg_i.tolerance_us) &&
      near_target(space_us, cfg_i.header_space_us, cfg_i.tolerance_us);
  assign match_o.one = levels_ok &&
      near_target(mark_us, cfg_i.bit_mark_us, cfg_i.tolerance_us) &&
      near_target(space_us, cfg_i.one_space_us, cfg_i.tolerance_us);
  assign match_o.zero = levels_ok &&
      near_target(mark_us, cfg_i.bit_mark_us, cfg_i.tolerance_us) &&
      near_target(space_us, cfg_i.zero_space_us, cfg_i.tolerance_us);

endmodule

>>> rtl/nec_ir_seq.sv
// Frame sequencer: phase, bit counter, shift word and result register.
`timescale 1ns / 1ps

module nec_ir_seq #(
  parameter int unsigned DATA_BITS = 32,
  localparam int unsigned CntW = $clog2(DATA_BITS + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         req_valid_i,
  input  logic                         buffer_end_i,
  input  nec_ir_pkg::match_t           match_i,
  input  logic                         out_stall_i,
  output logic                         out_valid_o,
  output logic [nec_ir_pkg::WordW-1:0] decoded_word_o,
  output logic                         advance_o,
  output nec_ir_pkg::phase_e           phase_o,
  output logic [CntW-1:0]              bits_o
);
  import nec_ir_pkg::*;

  phase_e            phase_q, phase_d;
  logic [CntW-1:0]   bits_q, bits_d;
  logic [CntW-1:0]   bits_inc;
  logic [WordW-1:0]  shift_q, shift_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  word_q, word_d;
  logic              fire;

  assign advance_o = !out_valid_q || !out_stall_i;
  assign fire      = req_valid_i && advance_o;
  assign bits_inc  = bits_q + CntW'(1);

  always_comb begin
    phase_d     = phase_q;
    bits_d      = bits_q;
    shift_d     = shift_q;
    word_d      = word_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (fire) begin
      unique case (phase_q)
        PH_HUNT: begin
          if (match_i.header) begin
            phase_d = PH_BITS;
            bits_d  = '0;
            shift_d = '0;
          end else begin
            phase_d = PH_DROP;
          end
        end
        PH_BITS: begin
          priority if (match_i.one) begin
            shift_d = {shift_q[WordW-2:0], 1'b1};
            bits_d  = bits_inc;
          end else if (match_i.zero) begin
            shift_d = {shift_q[WordW-2:0], 1'b0};
            bits_d  = bits_inc;
          end else begin
            phase_d = PH_DROP;
          end
          if ((match_i.one || match_i.zero) && (bits_inc >= CntW'(DATA_BITS))) begin
            phase_d = PH_END;
          end
        end
        PH_END: begin
          word_d      = shift_q;
          out_valid_d = 1'b1;
          phase_d     = PH_HUNT;
          bits_d      = '0;
          shift_d     = '0;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
      if (buffer_end_i) begin
        phase_d = PH_HUNT;
        bits_d  = '0;
        shift_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      bits_q      <= '0;
      shift_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      bits_q      <= bits_d;
      shift_q     <= shift_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign out_valid_o    = out_valid_q;
  assign decoded_word_o = word_q;
  assign phase_o        = phase_q;
  assign bits_o         = bits_q;

endmodule

>>> rtl/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder.
`timescale 1ns / 1ps

// Usage
//   Input channel: one captured pulse pair per request (levels, tick counts and
//   a buffer end flag) under in_valid_i / in_stall_o. Output channel: one
//   decoded 32-bit word per complete frame under out_valid_o / out_stall_i.
//   Configuration: write registers through cfg_we_i, cfg_idx_i and cfg_wdata_i
//   while the decoder is idle; writes take effect on the next cycle.
//   A request is registered, classified by the window compares and the
//   sequencer, and the word of a frame is written to the result register
//   when the sequencer takes its end pulse. Throughput: one pulse pair per
//   cycle when not stalled; the input register and the result register are
//   the only stages, and the window compares fit between them.
//   Stall: a held result blocks the sequencer only when the output register
//   is full and out_stall_i is high; then in_stall_o rises once the input
//   register holds a request, and both sides resume without loss.
//   Reset: configuration returns to the standard NEC timings with an active
//   low mark, and the decoder hunts for a header with an empty shift word.
module nec_ir_frame_decoder #(
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nec_ir_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [nec_ir_pkg::UsW-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           first_level_i,
  input  logic [nec_ir_pkg::TicksW-1:0]  first_ticks_i,
  input  logic                           second_level_i,
  input  logic [nec_ir_pkg::TicksW-1:0]  second_ticks_i,
  input  logic                           buffer_end_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [nec_ir_pkg::WordW-1:0]   decoded_word_o
);
  import nec_ir_pkg::*;

  localparam int unsigned CntW = $clog2(DATA_BITS + 1);

  cfg_t            cfg;
  match_t          match;
  pair_t           pair_q;
  logic            req_valid_q;
  logic            advance;
  phase_e          phase;
  logic [CntW-1:0] bits;

  nec_ir_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign in_stall_o = req_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      pair_q.first_level  <= first_level_i;
      pair_q.first_ticks  <= first_ticks_i;
      pair_q.second_level <= second_level_i;
      pair_q.second_ticks <= second_ticks_i;
      pair_q.buffer_end   <= buffer_end_i;
    end
  end

  nec_ir_match u_match (
    .pair_i  (pair_q),
    .cfg_i   (cfg),
    .match_o (match)
  );

  nec_ir_seq #(
    .DATA_BITS (DATA_BITS)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid_q),
    .buffer_end_i   (pair_q.buffer_end),
    .match_i        (match),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .decoded_word_o (decoded_word_o),
    .advance_o      (advance),
    .phase_o        (phase),
    .bits_o         (bits)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (req_valid_q && advance && pair_q.buffer_end)
      |=> (phase == PH_HUNT && bits == '0))
    else $error("buffer end did not return the decoder to header hunt");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (req_valid_q && advance && phase == PH_END) |=> out_valid_o)
    else $error("end pulse did not produce a decoded word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      bits <= CntW'(DATA_BITS))
    else $error("bit counter beyond frame length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      in_stall_o |-> (req_valid_q && out_valid_o))
    else $error("input stalled without a held request and result");

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the NEC infrared frame decoder: random frames against a predictor.
`timescale 1ns / 1ps

module tb_top;
  import nec_ir_pkg::*;

  localparam int unsigned DataBits   = 32;
  localparam int          MaxUs      = 40958;
  localparam int          MaxTicks   = 32767;
  localparam int          StallLimit = 1000;

  typedef enum int {DUR_IN, DUR_EDGE} dur_mode_e;
  typedef enum int {
    BUF_FRAME, BUF_TWO_FRAMES, BUF_FRAME_TAIL, BUF_SHORT_END, BUF_BROKEN, BUF_NOISE, BUF_TRUNC
  } buf_kind_e;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [UsW-1:0]      cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic                first_level_i;
  logic [TicksW-1:0]   first_ticks_i;
  logic                second_level_i;
  logic [TicksW-1:0]   second_ticks_i;
  logic                buffer_end_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [WordW-1:0]    decoded_word_o;

  nec_ir_frame_decoder #(.DATA_BITS(DataBits)) dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .first_level_i, .first_ticks_i,
    .second_level_i, .second_ticks_i, .buffer_end_i,
    .out_valid_o, .out_stall_i, .decoded_word_o
  );

  pair_t            pending_pairs[$];
  pair_t            buf_q[$];
  logic [WordW-1:0] expected_words[$];
  pair_t            drive_pair;

  cfg_t             cfg_model;
  phase_e           ir_phase;
  int               ir_bits;
  logic [WordW-1:0] ir_shift;

  bit pair_taken;
  bit word_taken;
  int idle_cycles;
  int mismatches;
  int gap_pct;
  int in_gap;
  int out_gap;
  int gen_count;
  int frames;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic bit in_window(input logic [TicksW-1:0] ticks, input logic [UsW-1:0] target);
    int us;
    int t;
    int m;
    us = int'(ticks);
    us = (us * 10) >> 3;
    t  = int'(target);
    m  = int'(cfg_model.tolerance_us);
    return (us < t + m) && (us > t - m);
  endfunction

  function automatic bit pair_fits(input pair_t p, input logic [UsW-1:0] mark,
                                   input logic [UsW-1:0] space);
    return (p.first_level == cfg_model.active_level) &&
           (p.second_level != cfg_model.active_level) &&
           in_window(p.first_ticks, mark) && in_window(p.second_ticks, space);
  endfunction

  function automatic void clear_frame();
    ir_phase = PH_HUNT;
    ir_bits  = 0;
    ir_shift = '0;
  endfunction

  function automatic bit decode_pair(input pair_t p, output logic [WordW-1:0] word);
    bit got;
    got  = 1'b0;
    word = '0;
    case (ir_phase)
      PH_HUNT: begin
        if (pair_fits(p, cfg_model.header_mark_us, cfg_model.header_space_us)) begin
          ir_phase = PH_BITS;
          ir_bits  = 0;
          ir_shift = '0;
        end else begin
          ir_phase = PH_DROP;
        end
      end
      PH_BITS: begin
        if (pair_fits(p, cfg_model.bit_mark_us, cfg_model.one_space_us)) begin
          ir_shift = {ir_shift[WordW-2:0], 1'b1};
          ir_bits++;
        end else if (pair_fits(p, cfg_model.bit_mark_us, cfg_model.zero_space_us)) begin
          ir_shift = {ir_shift[WordW-2:0], 1'b0};
          ir_bits++;
        end else begin
          ir_phase = PH_DROP;
        end
        if (ir_phase == PH_BITS && ir_bits >= int'(DataBits)) ir_phase = PH_END;
      end
      PH_END: begin
        word = ir_shift;
        got  = 1'b1;
        clear_frame();
      end
      default: ;
    endcase
    if (p.buffer_end) clear_frame();
    return got;
  endfunction

  function automatic logic [TicksW-1:0] dur_ticks(input int target, input dur_mode_e mode);
    int tol;
    int off;
    int us;
    int tk;
    tol = int'(cfg_model.tolerance_us);
    off = 0;
    if (mode == DUR_IN) begin
      if (tol > 2) off = int'($urandom_range(0, 2 * (tol - 2))) - (tol - 2);
    end else begin
      case ($urandom_range(0, 3))
        0:       off = -tol;
        1:       off = 1 - tol;
        2:       off = tol - 1;
        default: off = tol;
      endcase
    end
    us = target + off;
    if (us < 0) us = 0;
    if (us > MaxUs) us = MaxUs;
    tk = (us * 8 + 9) / 10;
    if (tk > MaxTicks) tk = MaxTicks;
    return tk[TicksW-1:0];
  endfunction

  function automatic pair_t mk_raw(input bit l0, input logic [TicksW-1:0] t0, input bit l1,
                                   input logic [TicksW-1:0] t1, input bit last);
    pair_t p;
    p.first_level  = l0;
    p.first_ticks  = t0;
    p.second_level = l1;
    p.second_ticks = t1;
    p.buffer_end   = last;
    return p;
  endfunction

  function automatic pair_t mk_pair(input int mark, input int space, input dur_mode_e mode);
    return mk_raw(cfg_model.active_level, dur_ticks(mark, mode), ~cfg_model.active_level,
                  dur_ticks(space, mode), 1'b0);
  endfunction

  function automatic pair_t random_pair();
    return mk_raw(1'($urandom_range(0, 1)), TicksW'($urandom_range(0, MaxTicks)),
                  1'($urandom_range(0, 1)), TicksW'($urandom_range(0, MaxTicks)), 1'b0);
  endfunction

  task automatic push_header();
    buf_q.push_back(mk_pair(cfg_model.header_mark_us, cfg_model.header_space_us, DUR_IN));
  endtask

  task automatic push_bits(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 1))
        buf_q.push_back(mk_pair(cfg_model.bit_mark_us, cfg_model.one_space_us, DUR_IN));
      else
        buf_q.push_back(mk_pair(cfg_model.bit_mark_us, cfg_model.zero_space_us, DUR_IN));
    end
  endtask

  task automatic push_frame();
    push_header();
    push_bits(DataBits);
  endtask

  task automatic push_noise();
    pair_t p;
    case ($urandom_range(0, 4))
      0: p = mk_pair(cfg_model.header_mark_us, cfg_model.header_space_us, DUR_EDGE);
      1: p = mk_pair(cfg_model.bit_mark_us, cfg_model.one_space_us, DUR_EDGE);
      2: begin
        p = mk_pair(cfg_model.header_mark_us, cfg_model.header_space_us, DUR_IN);
        p.first_level  = ~p.first_level;
        p.second_level = ~p.second_level;
      end
      3: p = mk_pair(cfg_model.header_mark_us, cfg_model.header_space_us, DUR_IN);
      default: p = random_pair();
    endcase
    buf_q.push_back(p);
  endtask

  task automatic push_broken();
    pair_t p;
    int    space;
    space = $urandom_range(0, 1) ? cfg_model.one_space_us : cfg_model.zero_space_us;
    p = mk_pair(cfg_model.bit_mark_us, space, DUR_IN);
    case ($urandom_range(0, 4))
      0: p.first_level  = ~p.first_level;
      1: p.second_level = p.first_level;
      2: p.first_ticks  = dur_ticks(cfg_model.bit_mark_us, DUR_EDGE);
      3: p.second_ticks = dur_ticks(space, DUR_EDGE);
      default: p = random_pair();
    endcase
    buf_q.push_back(p);
  endtask

  task automatic add_buffer();
    buf_kind_e kind;
    int        r;
    r = $urandom_range(0, 99);
    if (r < 40)      kind = BUF_FRAME;
    else if (r < 50) kind = BUF_TWO_FRAMES;
    else if (r < 58) kind = BUF_FRAME_TAIL;
    else if (r < 66) kind = BUF_SHORT_END;
    else if (r < 80) kind = BUF_BROKEN;
    else if (r < 92) kind = BUF_NOISE;
    else             kind = BUF_TRUNC;
    buf_q.delete();
    case (kind)
      BUF_FRAME: begin
        push_frame();
        push_noise();
        frames++;
      end
      BUF_TWO_FRAMES: begin
        push_frame();
        push_noise();
        push_frame();
        push_noise();
        frames += 2;
      end
      BUF_FRAME_TAIL: begin
        push_frame();
        push_noise();
        repeat ($urandom_range(1, 4)) push_noise();
        frames++;
      end
      BUF_SHORT_END: push_frame();
      BUF_BROKEN: begin
        push_header();
        push_bits($urandom_range(0, DataBits - 1));
        push_broken();
        repeat ($urandom_range(0, 5)) push_bits(1);
      end
      BUF_NOISE: repeat ($urandom_range(1, 6)) push_noise();
      default: begin
        push_header();
        push_bits($urandom_range(0, DataBits - 1));
      end
    endcase
    buf_q[buf_q.size() - 1].buffer_end = 1'b1;
    foreach (buf_q[i]) pending_pairs.push_back(buf_q[i]);
    gen_count += buf_q.size();
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_pairs.size() != 0 || in_valid_i || expected_words.size() != 0)
      @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_idx_e idx, input logic [UsW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ACTIVE_LEVEL: cfg_model.active_level    = val[0];
      CFG_HDR_MARK:     cfg_model.header_mark_us  = val;
      CFG_HDR_SPACE:    cfg_model.header_space_us = val;
      CFG_BIT_MARK:     cfg_model.bit_mark_us     = val;
      CFG_ONE_SPACE:    cfg_model.one_space_us    = val;
      CFG_ZERO_SPACE:   cfg_model.zero_space_us   = val;
      CFG_TOLERANCE:    cfg_model.tolerance_us    = val;
      default: ;
    endcase
  endtask

  task automatic write_config(input bit al, input int hm, input int hs, input int bm,
                              input int os, input int zs, input int tol);
    logic [UsW-1:0] lvl;
    lvl    = UsW'($urandom_range(0, 65535));
    lvl[0] = al;
    put_reg(CFG_ACTIVE_LEVEL, lvl);
    put_reg(CFG_HDR_MARK, hm[UsW-1:0]);
    put_reg(CFG_HDR_SPACE, hs[UsW-1:0]);
    put_reg(CFG_BIT_MARK, bm[UsW-1:0]);
    put_reg(CFG_ONE_SPACE, os[UsW-1:0]);
    put_reg(CFG_ZERO_SPACE, zs[UsW-1:0]);
    put_reg(CFG_TOLERANCE, tol[UsW-1:0]);
    put_reg(CFG_UNUSED, UsW'($urandom_range(0, 65535)));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input int pct, input int target, input int min_frames);
    gap_pct   = pct;
    gen_count = 0;
    frames    = 0;
    while (gen_count < target || frames < min_frames) add_buffer();
    wait_idle();
  endtask

  // driver and receiver: change at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || pair_taken) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() == 0) begin
          in_valid_i <= 1'b0;
        end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
          in_gap = $urandom_range(0, 10);
          in_valid_i <= 1'b0;
        end else begin
          drive_pair = pending_pairs.pop_front();
          first_level_i  <= drive_pair.first_level;
          first_ticks_i  <= drive_pair.first_ticks;
          second_level_i <= drive_pair.second_level;
          second_ticks_i <= drive_pair.second_ticks;
          buffer_end_i   <= drive_pair.buffer_end;
          in_valid_i     <= 1'b1;
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall_i <= 1'b1;
      end else if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
        out_gap = $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // monitor: sample at the rising edge
  always @(posedge clk_i) begin : monitor
    pair_t            seen;
    logic [WordW-1:0] word;
    logic [WordW-1:0] want;
    if (!rst_ni) begin
      pair_taken  = 1'b0;
      word_taken  = 1'b0;
      idle_cycles = 0;
    end else begin
      pair_taken = in_valid_i && !in_stall_o;
      word_taken = out_valid_o && !out_stall_i;
      if (word_taken) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          $display("%0t: decoded_word expected none actual %08h", $time, decoded_word_o);
        end else begin
          want = expected_words.pop_front();
          if (decoded_word_o !== want) begin
            mismatches++;
            $display("%0t: decoded_word expected %08h actual %08h", $time, want,
                     decoded_word_o);
          end
        end
      end
      if (pair_taken) begin
        seen = mk_raw(first_level_i, first_ticks_i, second_level_i, second_ticks_i,
                      buffer_end_i);
        if (decode_pair(seen, word)) expected_words.push_back(word);
      end
      if (pair_taken || word_taken || cfg_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_ACTIVE_LEVEL;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    first_level_i  = 1'b0;
    first_ticks_i  = '0;
    second_level_i = 1'b0;
    second_ticks_i = '0;
    buffer_end_i   = 1'b0;
    out_stall_i    = 1'b0;
    mismatches     = 0;
    gap_pct        = 0;
    in_gap         = 0;
    out_gap        = 0;
    cfg_model.active_level    = 1'b0;
    cfg_model.header_mark_us  = HdrMarkRst;
    cfg_model.header_space_us = HdrSpaceRst;
    cfg_model.bit_mark_us     = BitMarkRst;
    cfg_model.one_space_us    = OneSpaceRst;
    cfg_model.zero_space_us   = ZeroSpaceRst;
    cfg_model.tolerance_us    = TolRst;
    clear_frame();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // window edges, level faults and buffer ends under the reset timings
    gap_pct = 20;
    pending_pairs.push_back(mk_raw(0, 0, 0, 0, 0));
    pending_pairs.push_back(mk_raw(1, 15'd32767, 1, 15'd32767, 1));
    pending_pairs.push_back(mk_raw(0, 15'd7200, 1, 15'd3600, 0));
    pending_pairs.push_back(mk_raw(0, 15'd448, 1, 15'd608, 1));
    pending_pairs.push_back(mk_raw(0, 15'd7200, 1, 15'd3600, 0));
    pending_pairs.push_back(mk_raw(0, 15'd289, 1, 15'd1511, 0));
    pending_pairs.push_back(mk_raw(0, 15'd289, 1, 15'd289, 0));
    pending_pairs.push_back(mk_raw(0, 15'd288, 1, 15'd448, 1));
    pending_pairs.push_back(mk_raw(0, 15'd7041, 1, 15'd3600, 0));
    pending_pairs.push_back(mk_raw(0, 15'd448, 1, 15'd1193, 1));
    pending_pairs.push_back(mk_raw(0, 15'd7200, 1, 15'd3440, 1));
    pending_pairs.push_back(mk_raw(1, 15'd7200, 0, 15'd3600, 1));
    pending_pairs.push_back(mk_raw(0, 15'd7200, 0, 15'd3600, 1));
    pending_pairs.push_back(mk_raw(0, 15'd7200, 1, 15'd3600, 1));
    pending_pairs.push_back(mk_raw(0, 15'd7359, 1, 15'd3759, 0));
    pending_pairs.push_back(mk_raw(0, 15'd608, 1, 15'd448, 0));
    pending_pairs.push_back(mk_raw(0, 15'd32767, 1, 15'd0, 1));
    repeat (4) pending_pairs.push_back(random_pair());
    pending_pairs.push_back(mk_raw(1, 15'd0, 0, 15'd32767, 1));
    wait_idle();

    run_phase(25, 200, 4);

    write_config(1'b1, HdrMarkRst, HdrSpaceRst, BitMarkRst, OneSpaceRst, ZeroSpaceRst, TolRst);
    run_phase(10, 200, 5);

    write_config(1'b0, HdrMarkRst, HdrSpaceRst, BitMarkRst, OneSpaceRst, ZeroSpaceRst, 0);
    run_phase(40, 40, 0);

    write_config(1'b1, 0, 40959, 20000, 12345, 30000, 40959);
    run_phase(0, 160, 5);

    write_config(1'b1, 0, 0, 0, 40959, 0, 150);
    run_phase(25, 200, 5);

    write_config(1'b0, 40959, 40959, 40959, 40959, 0, 3);
    run_phase(15, 200, 5);

    write_config(1'($urandom_range(0, 1)), 3000, 1500, 400, 600, 700, 200);
    run_phase(5, 150, 5);

    repeat (2) begin
      write_config(1'($urandom_range(0, 1)), $urandom_range(5000, 20000),
                   $urandom_range(2000, 8000),
                   $urandom_range(200, 1500), $urandom_range(1000, 3000),
                   $urandom_range(200, 1500), $urandom_range(20, 600));
      run_phase(30, 200, 5);
    end

    write_config(1'b0, HdrMarkRst, HdrSpaceRst, BitMarkRst, OneSpaceRst, ZeroSpaceRst, TolRst);
    run_phase(0, 200, 5);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule
